/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the field multiplier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Plain expression that must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    `ASSERT_PROP(lbl, clk, rstn, (expr), msg)

`endif

/* sv/mfm_pkg.sv */
// ----------------------------------------------------------------------------
// mfm_pkg
// Types and constants of the Montgomery field multiplier (p = 2^251+17*2^192+1).
// ----------------------------------------------------------------------------
package mfm_pkg;

    localparam int WORD_W  = 64;
    localparam int VAL_W   = 4 * WORD_W;
    localparam int WIN_W   = 6 * WORD_W;
    localparam int NUM_RND = 4;

    // top word of p, of 16p and of 32p (the latter truncated to a word)
    localparam logic [63:0] P3_WORD   = 64'h0800_0000_0000_0011;
    localparam logic [63:0] P3_X16    = 64'h8000_0000_0000_0110;
    localparam logic [63:0] P3_X32_W3 = 64'd544;
    localparam logic [63:0] LOW_X16   = 64'd16;
    localparam logic [63:0] LOW_X32   = 64'd32;

    // top bits of a value that count whole multiples of p
    localparam int H_LSB = 251;

    localparam logic [VAL_W-1:0] P_FULL   = {P3_WORD, 128'd0, 64'd1};
    localparam logic [VAL_W-1:0] MONT_R2  = {64'h07ff_d4ab_5e00_8810, 64'hffff_ffff_ff6f_8000,
                                             64'h0000_0001_330f_ffff, 64'hffff_fd73_7e00_0401};
    localparam logic [VAL_W-1:0] ONE_VAL  = {{(VAL_W-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {
        OP_MUL       = 2'd0,
        OP_CUBE      = 2'd1,
        OP_TO_MONT   = 2'd2,
        OP_FROM_MONT = 2'd3
    } op_t;

    // sideband that rides along with an item through the product chains
    typedef struct packed {
        op_t              op;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] r;
    } mfm_side_t;

endpackage

/* sv/mfm_in_if.sv */
// ----------------------------------------------------------------------------
// mfm_in_if
// Request channel: operation code and two 256-bit operands.
// ----------------------------------------------------------------------------
interface mfm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] x_w0;
    logic [63:0] x_w1;
    logic [63:0] x_w2;
    logic [63:0] x_w3;
    logic [63:0] y_w0;
    logic [63:0] y_w1;
    logic [63:0] y_w2;
    logic [63:0] y_w3;

    modport source (output valid, operation, x_w0, x_w1, x_w2, x_w3,
                    y_w0, y_w1, y_w2, y_w3, input ready);
    modport sink   (input valid, operation, x_w0, x_w1, x_w2, x_w3,
                    y_w0, y_w1, y_w2, y_w3, output ready);
endinterface

/* sv/mfm_out_if.sv */
// ----------------------------------------------------------------------------
// mfm_out_if
// Result channel: one 256-bit value per item.
// ----------------------------------------------------------------------------
interface mfm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] z_w0;
    logic [63:0] z_w1;
    logic [63:0] z_w2;
    logic [63:0] z_w3;

    modport source (output valid, z_w0, z_w1, z_w2, z_w3, input ready);
    modport sink   (input valid, z_w0, z_w1, z_w2, z_w3, output ready);
endinterface

/* sv/mfm_cell.sv */
// ----------------------------------------------------------------------------
// mfm_cell
// One Montgomery round over a six-word window, three register stages:
// partial products, accumulate a_i*b, then add u*p with u = -w0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfm_cell
    import mfm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  logic [WIN_W-1:0] win_in,
    input  logic [VAL_W-1:0] a_in,
    input  logic [VAL_W-1:0] b_in,
    input  mfm_side_t        side_in,
    output logic             vld_out,
    output logic [WIN_W-1:0] win_out,
    output logic [VAL_W-1:0] a_out,
    output logic [VAL_W-1:0] b_out,
    output mfm_side_t        side_out
);

    logic             vld1_reg, vld2_reg, vld3_reg;
    logic [63:0]      pp_reg   [4][4];
    logic [63:0]      pp_next  [4][4];
    logic [WIN_W-1:0] win1_reg, win2_reg, win3_reg;
    logic [WIN_W-1:0] win2_next, win3_next;
    logic [VAL_W-1:0] a1_reg, a2_reg, a3_reg;
    logic [VAL_W-1:0] b1_reg, b2_reg, b3_reg;
    mfm_side_t        s1_reg, s2_reg, s3_reg;
    logic [127:0]     prod [4];
    logic [319:0]     acc;
    logic [63:0]      u;
    logic [WIN_W-1:0] up;

    // stage 1: 32x32 partial products of a_i with every word of b
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            pp_next[j][0] = {32'd0, a_in[31:0]}  * {32'd0, b_in[64*j +: 32]};
            pp_next[j][1] = {32'd0, a_in[31:0]}  * {32'd0, b_in[64*j+32 +: 32]};
            pp_next[j][2] = {32'd0, a_in[63:32]} * {32'd0, b_in[64*j +: 32]};
            pp_next[j][3] = {32'd0, a_in[63:32]} * {32'd0, b_in[64*j+32 +: 32]};
        end
    end

    // stage 2: combine partials and add into the low five words
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            prod[j] = {64'd0, pp_reg[j][0]} + {32'd0, pp_reg[j][1], 32'd0}
                    + {32'd0, pp_reg[j][2], 32'd0} + {pp_reg[j][3], 64'd0};
        end
        acc = win1_reg[319:0] + {192'd0, prod[0]} + {128'd0, prod[1], 64'd0}
            + {64'd0, prod[2], 128'd0} + {prod[3], 192'd0};
        win2_next = {win1_reg[383:320], acc};
    end

    // stage 3: u*p = u + u*(2^59+17)*2^192, clears the low word
    always_comb
    begin
        u         = 64'd0 - win2_reg[63:0];
        up        = {320'd0, u} + ({320'd0, u} << 192) + ({320'd0, u} << 196)
                  + ({320'd0, u} << 251);
        win3_next = win2_reg + up;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg   <= pp_next;
            win1_reg <= win_in;
            a1_reg   <= a_in;
            b1_reg   <= b_in;
            s1_reg   <= side_in;
            win2_reg <= win2_next;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            s2_reg   <= s1_reg;
            win3_reg <= win3_next;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            s3_reg   <= s2_reg;
        end
    end

    assign vld_out  = vld3_reg;
    assign win_out  = win3_reg;
    assign a_out    = a3_reg;
    assign b_out    = b3_reg;
    assign side_out = s3_reg;

    `ASSERT_ALWAYS(a_low_word_cleared, clk, rst_n, !vld3_reg || (win3_reg[63:0] == 64'd0), "round left a nonzero low word")

endmodule

/* sv/mfm_mult.sv */
// ----------------------------------------------------------------------------
// mfm_mult
// Montgomery product a*b*2^-256: a chain of four round cells, then the
// registered overflow reduction into 256 bits.
// ----------------------------------------------------------------------------
module mfm_mult
    import mfm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  logic [VAL_W-1:0] a_in,
    input  logic [VAL_W-1:0] b_in,
    input  mfm_side_t        side_in,
    output logic             vld_out,
    output logic [VAL_W-1:0] z_out,
    output mfm_side_t        side_out
);

    logic             c_vld  [NUM_RND+1];
    logic [WIN_W-1:0] c_win  [NUM_RND+1];
    logic [WIN_W-1:0] c_wout [NUM_RND];
    logic [VAL_W-1:0] c_a    [NUM_RND+1];
    logic [VAL_W-1:0] c_aout [NUM_RND];
    logic [VAL_W-1:0] c_b    [NUM_RND+1];
    mfm_side_t        c_side [NUM_RND+1];

    logic             ov_vld_reg;
    logic [VAL_W-1:0] ov_z_reg, ov_z_next;
    mfm_side_t        ov_side_reg;
    logic [319:0]     t;
    logic [VAL_W-1:0] sub_val;

    assign c_vld[0]  = vld_in;
    assign c_win[0]  = '0;
    assign c_a[0]    = a_in;
    assign c_b[0]    = b_in;
    assign c_side[0] = side_in;

    // one cell per word of a; window and a move down one word between cells
    for (genvar g = 0; g < NUM_RND; g++)
    begin : g_cell
        mfm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (c_vld[g]),
            .win_in   (c_win[g]),
            .a_in     (c_a[g]),
            .b_in     (c_b[g]),
            .side_in  (c_side[g]),
            .vld_out  (c_vld[g+1]),
            .win_out  (c_wout[g]),
            .a_out    (c_aout[g]),
            .b_out    (c_b[g+1]),
            .side_out (c_side[g+1])
        );
        assign c_win[g+1] = {64'd0, c_wout[g][WIN_W-1:64]};
        assign c_a[g+1]   = {64'd0, c_aout[g][VAL_W-1:64]};
    end

    // overflow reduction on bits 256 and 255 of the 257-bit value
    always_comb
    begin
        t = c_win[NUM_RND][319:0];
        sub_val = '0;
        if (t[256])
        begin
            if (t[255])
            begin
                sub_val = {P3_X32_W3, 128'd0, LOW_X32};
            end
            else
            begin
                sub_val = {P3_X16, 128'd0, LOW_X16};
            end
        end
        ov_z_next = t[255:0] - sub_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_vld_reg <= c_vld[NUM_RND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ov_z_reg    <= ov_z_next;
            ov_side_reg <= c_side[NUM_RND];
        end
    end

    assign vld_out  = ov_vld_reg;
    assign z_out    = ov_z_reg;
    assign side_out = ov_side_reg;

endmodule

/* sv/montgomery_field_multiplier_core.sv */
// ----------------------------------------------------------------------------
// montgomery_field_multiplier_core
// Pipelined Montgomery multiplier mod p = 2^251 + 17*2^192 + 1.
//
//   channel  dir  modport  contents
//   req      in   sink     operation, x_w0..x_w3, y_w0..y_w3
//   rsp      out  source   z_w0..z_w3
//
// One item enters per cycle while the pipeline is not frozen. Each item goes
// through two product chains of four round cells (3 stages each) plus an
// overflow stage, one final reduction stage and the output register.
// The second chain does the second product of a cube; other items pass it.
// The whole pipeline advances together; it freezes only while a result
// sits in the output register untaken. Reset clears the valid bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module montgomery_field_multiplier_core
    import mfm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mfm_in_if.sink   req,
    mfm_out_if.source rsp
);

    logic             adv;
    op_t              op_in;
    logic [VAL_W-1:0] x_in, y_in, b_sel;
    mfm_side_t        side_a;

    logic             va_vld, vb_vld;
    logic [VAL_W-1:0] za, zb;
    mfm_side_t        sa, sb, side_b;

    logic             fr_vld_reg;
    logic [VAL_W-1:0] fr_z_reg, fr_z_next;
    logic             fr_brw_reg, fr_brw_next;
    logic [VAL_W-1:0] sel;
    logic [4:0]       h;
    logic [63:0]      hp3;
    logic [VAL_W:0]   diff;

    logic             rsp_vld_reg;
    logic [VAL_W-1:0] rsp_z_reg, rsp_z_next;

    // pipeline moves unless a result waits untaken
    assign adv       = !rsp_vld_reg || rsp.ready;
    assign req.ready = adv;

    assign op_in = op_t'(req.operation);
    assign x_in  = {req.x_w3, req.x_w2, req.x_w1, req.x_w0};
    assign y_in  = {req.y_w3, req.y_w2, req.y_w1, req.y_w0};

    // second operand of the first product
    always_comb
    begin
        unique case (op_in)
            OP_MUL:     b_sel = y_in;
            OP_CUBE:    b_sel = x_in;
            OP_TO_MONT: b_sel = MONT_R2;
            default:    b_sel = ONE_VAL;
        endcase
    end

    assign side_a = '{op: op_in, x: x_in, r: '0};

    mfm_mult u_mult_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (req.valid),
        .a_in     (x_in),
        .b_in     (b_sel),
        .side_in  (side_a),
        .vld_out  (va_vld),
        .z_out    (za),
        .side_out (sa)
    );

    // first result rides along as sideband
    assign side_b = '{op: sa.op, x: sa.x, r: za};

    mfm_mult u_mult_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (va_vld),
        .a_in     (za),
        .b_in     (sa.x),
        .side_in  (side_b),
        .vld_out  (vb_vld),
        .z_out    (zb),
        .side_out (sb)
    );

    // pick the product, subtract h*p for the leave-Montgomery case
    always_comb
    begin
        sel  = (sb.op == OP_CUBE) ? zb : sb.r;
        h    = sel[VAL_W-1:H_LSB];
        hp3  = ({59'd0, h} << 59) + ({59'd0, h} << 4) + {59'd0, h};
        diff = {1'b0, sel} - {1'b0, hp3, 128'd0, 59'd0, h};
        if (sb.op == OP_FROM_MONT)
        begin
            fr_z_next   = diff[VAL_W-1:0];
            fr_brw_next = diff[VAL_W];
        end
        else
        begin
            fr_z_next   = sel;
            fr_brw_next = 1'b0;
        end
    end

    // add p back after a borrow
    assign rsp_z_next = fr_brw_reg ? (fr_z_reg + P_FULL) : fr_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_vld_reg  <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            fr_vld_reg  <= vb_vld;
            rsp_vld_reg <= fr_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fr_z_reg   <= fr_z_next;
            fr_brw_reg <= fr_brw_next;
            rsp_z_reg  <= rsp_z_next;
        end
    end

    assign rsp.valid = rsp_vld_reg;
    assign rsp.z_w0  = rsp_z_reg[63:0];
    assign rsp.z_w1  = rsp_z_reg[127:64];
    assign rsp.z_w2  = rsp_z_reg[191:128];
    assign rsp.z_w3  = rsp_z_reg[255:192];

    `ASSERT_PROP(a_stall_holds, clk, rst_n, (!adv && fr_vld_reg) |=> $stable(fr_z_reg), "pipeline moved during stall")
    `ASSERT_PROP(a_item_reaches_out, clk, rst_n, (adv && fr_vld_reg) |=> rsp_vld_reg, "item lost before output")

endmodule

/* bench/montgomery_field_multiplier_core_tb.sv */
// ----------------------------------------------------------------------------
// montgomery_field_multiplier_core_tb
// Drives operation items through the field multiplier and compares each
// result word by word with a bit-exact software product computed here.
// ----------------------------------------------------------------------------
module montgomery_field_multiplier_core_tb;
    import mfm_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam logic [255:0] ALL_ONES = {256{1'b1}};

    logic clk;
    logic rst_n;

    mfm_in_if  req ();
    mfm_out_if rsp ();

    montgomery_field_multiplier_core uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // expected results, oldest first
    logic [255:0] field_results_q[$];
    int           error_count;
    int           idle_cycles;
    int           send_idle_pct;
    int           stall_pct;
    int           hold_off_cycles;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // one Montgomery product x*y*2^-256 with the overflow fold into 256 bits;
    // each round works on a six-word window, and x_i*y is added into its
    // low five words only, so a carry out of them is dropped
    function automatic logic [255:0] mont_product(logic [255:0] x, logic [255:0] y);
        logic [383:0] win;
        logic [319:0] acc;
        logic [63:0]  u;
        logic [256:0] t;
        logic [255:0] s;
        win = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc = win[319:0] + x[64*i +: 64] * {64'd0, y};
            win = {win[383:320], acc};
            u   = 64'd0 - win[63:0];
            win = win + {320'd0, u} * {128'd0, P_FULL};
            win = win >> 64;
        end
        t = win[256:0];
        s = '0;
        if (t[256])
        begin
            s[63:0]    = t[255] ? LOW_X32 : LOW_X16;
            s[255:192] = t[255] ? P3_X32_W3 : P3_X16;
        end
        return t[255:0] - s;
    endfunction

    // full reduction into [0,p)
    function automatic logic [255:0] reduce_full(logic [255:0] v);
        logic [63:0]  h;
        logic [256:0] d;
        logic [255:0] s;
        h = {59'd0, v[255:251]};
        s = {h * P3_WORD, 128'd0, h};
        d = {1'b0, v} - {1'b0, s};
        return d[256] ? d[255:0] + P_FULL : d[255:0];
    endfunction

    function automatic logic [255:0] field_result(op_t op, logic [255:0] x, logic [255:0] y);
        case (op)
            OP_MUL:     return mont_product(x, y);
            OP_CUBE:    return mont_product(mont_product(x, x), x);
            OP_TO_MONT: return mont_product(x, MONT_R2);
            default:    return reduce_full(mont_product(x, ONE_VAL));
        endcase
    endfunction

    function automatic logic [255:0] rand_val();
        logic [255:0] v;
        for (int i = 0; i < 8; i++)
            v[32*i +: 32] = $urandom;
        case ($urandom_range(0, 7))
            0: v = v % P_FULL;
            1: v = v >> $urandom_range(0, 255);
            2: v = ALL_ONES - (v >> $urandom_range(8, 255));
            3: v = P_FULL + $urandom_range(0, 3) - 2;
            default: ;
        endcase
        return v;
    endfunction

    // send one item and record its expected result; valid stays high after
    // the accept so the next item can follow in the very next cycle
    task automatic send_item(op_t op, logic [255:0] x, logic [255:0] y);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        {req.x_w3, req.x_w2, req.x_w1, req.x_w0} <= x;
        {req.y_w3, req.y_w2, req.y_w1, req.y_w0} <= y;
        field_results_q.push_back(field_result(op, x, y));
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (field_results_q.size() != 0)
            @(negedge clk);
    endtask

    // extremes, each operation, operands at and above p, ignored y
    task automatic test_directed();
        logic [255:0] vals[6];
        vals = '{256'd0, 256'd1, P_FULL - 1, P_FULL, P_FULL + 1, ALL_ONES};
        foreach (vals[i])
            send_item(OP_MUL, vals[i], vals[5 - i]);
        send_item(OP_MUL, ALL_ONES, ALL_ONES);
        foreach (vals[i])
            send_item(OP_CUBE, vals[i], ALL_ONES);
        send_item(OP_TO_MONT, ALL_ONES, ALL_ONES);
        send_item(OP_TO_MONT, P_FULL, 256'd0);
        send_item(OP_TO_MONT, 256'd0, 256'd5);
        foreach (vals[i])
            send_item(OP_FROM_MONT, vals[i], rand_val());
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_item(op_t'($urandom_range(0, 3)), rand_val(), rand_val());
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_off_cycles = 200;
        test_random(60);
        wait_drained();
    endtask

    // receiver ready
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        logic [255:0] got;
        logic [255:0] want;
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("montgomery_field_multiplier_core_tb: done, errors");
                $finish;
            end
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.z_w3, rsp.z_w2, rsp.z_w1, rsp.z_w0};
                if (field_results_q.size() == 0)
                begin
                    $display("%0t: result with none expected: got %h", $time, got);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = field_results_q.pop_front();
                    for (int w = 0; w < 4; w++)
                        if (got[64*w +: 64] !== want[64*w +: 64])
                        begin
                            $display("%0t: z_w%0d expected %h actual %h",
                                     $time, w, want[64*w +: 64], got[64*w +: 64]);
                            error_count = error_count + 1;
                        end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_cycles = 0;
        req.valid = 1'b0;
        req.operation = OP_MUL;
        {req.x_w3, req.x_w2, req.x_w1, req.x_w0} = '0;
        {req.y_w3, req.y_w2, req.y_w1, req.y_w0} = '0;
        rsp.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(140);
        send_idle_pct = 72;
        test_random(110);
        send_idle_pct = 0;
        stall_pct = 72;
        test_random(110);
        send_idle_pct = 6;
        stall_pct = 6;
        test_random(110);
        stall_pct = 0;
        test_backpressure();

        wait_drained();
        repeat (40) @(posedge clk);
        if (error_count == 0 && field_results_q.size() == 0)
            $display("montgomery_field_multiplier_core_tb: done, clean");
        else
            $display("montgomery_field_multiplier_core_tb: done, errors");
        $finish;
    end

endmodule

/* montgomery_field_multiplier_core.f */
+incdir+sv
sv/mfm_pkg.sv
sv/mfm_in_if.sv
sv/mfm_out_if.sv
sv/mfm_cell.sv
sv/mfm_mult.sv
sv/montgomery_field_multiplier_core.sv
bench/montgomery_field_multiplier_core_tb.sv
